// File: hdl/bgpe_pkg.sv
`timescale 1ns / 1ps

package bgpe_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ColW     = 5;
  localparam int unsigned ByteCntW = 7;
  localparam int unsigned SizeW    = 2;
  localparam int unsigned BitIdxW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_FG_COLOR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BG_COLOR = 2'd1;

  localparam logic [ColorW-1:0] FG_RESET = 16'hFFFF;
  localparam logic [ColorW-1:0] BG_RESET = 16'h0000;

  // Size codes
  localparam logic [SizeW-1:0] SIZE_12 = 2'd0;
  localparam logic [SizeW-1:0] SIZE_16 = 2'd1;
  localparam logic [SizeW-1:0] SIZE_24 = 2'd2;
  localparam logic [SizeW-1:0] SIZE_32 = 2'd3;

  // Half of the glyph height: columns in one glyph row
  function automatic logic [ColW-1:0] half_of(input logic [SizeW-1:0] code);
    logic [ColW-1:0] h;
    case (code)
      SIZE_12: h = 5'd6;
      SIZE_16: h = 5'd8;
      SIZE_24: h = 5'd12;
      SIZE_32: h = 5'd16;
      default: h = 5'd16;
    endcase
    return h;
  endfunction

  // Bytes that make up one glyph
  function automatic logic [ByteCntW-1:0] bytes_of(input logic [SizeW-1:0] code);
    logic [ByteCntW-1:0] n;
    case (code)
      SIZE_12: n = 7'd12;
      SIZE_16: n = 7'd16;
      SIZE_24: n = 7'd48;
      SIZE_32: n = 7'd64;
      default: n = 7'd64;
    endcase
    return n;
  endfunction

endpackage

// File: hdl/bgpe_in_if.sv
`timescale 1ns / 1ps

interface bgpe_in_if;
  logic                          valid;
  logic                          ready;
  logic                          glyph_start;
  logic [bgpe_pkg::CoordW-1:0]   origin_x;
  logic [bgpe_pkg::CoordW-1:0]   origin_y;
  logic [bgpe_pkg::SizeW-1:0]    size_code;
  logic                          transparent;
  logic [bgpe_pkg::ByteW-1:0]    font_byte;

  modport source (output valid, glyph_start, origin_x, origin_y, size_code, transparent,
                  font_byte, input ready);
  modport sink (input valid, glyph_start, origin_x, origin_y, size_code, transparent,
                font_byte, output ready);
endinterface

// File: hdl/bgpe_out_if.sv
`timescale 1ns / 1ps

interface bgpe_out_if;
  logic                          valid;
  logic                          ready;
  logic [bgpe_pkg::CoordW-1:0]   pixel_x;
  logic [bgpe_pkg::CoordW-1:0]   pixel_y;
  logic [bgpe_pkg::ColorW-1:0]   pixel_color;
  logic                          last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

// File: hdl/bitmap_glyph_pixel_expander_unit.sv
`timescale 1ns / 1ps

// Channel  | Dir | Transfer when       | Payload
// in_ch    | in  | valid && ready      | glyph_start, origin_x/y, size_code, transparent,
//          |     |                     | font_byte
// out_ch   | out | valid && ready      | pixel_x, pixel_y, pixel_color, last
// cfg_*    | in  | cfg_we              | cfg_idx (0 fg_color, 1 bg_color), cfg_data
//
// A font byte is decoded into a pixel job in the cycle it is transferred; the job
// register then issues one pixel per cycle into the output register, one for each
// bit that the byte writes (0 to 8), and a byte that writes nothing leaves the job
// empty. The next byte is taken while the last pixel of the current one moves out.
// Output stalls hold the job; rst_n is synchronous and clears all control state.

module bitmap_glyph_pixel_expander_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  bgpe_in_if.sink                         in_ch,
  bgpe_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bgpe_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [bgpe_pkg::CfgDataW-1:0]   cfg_data
);

  // Configuration registers
  logic [bgpe_pkg::ColorW-1:0] fg_color_r, bg_color_r;

  // Glyph state
  logic [bgpe_pkg::CoordW-1:0]   base_x_r, base_x_nxt;
  logic [bgpe_pkg::CoordW-1:0]   cur_y_r, cur_y_nxt;
  logic [bgpe_pkg::ColW-1:0]     col_r, col_nxt;
  logic [bgpe_pkg::ByteCntW-1:0] bcnt_r, bcnt_nxt;
  logic [bgpe_pkg::SizeW-1:0]    size_r, size_nxt;
  logic                          transp_r, transp_nxt;
  logic                          active_r, active_nxt;

  // Pixel job
  logic [bgpe_pkg::CoordW-1:0]   job_x_r;
  logic [bgpe_pkg::CoordW-1:0]   job_y_r;
  logic [bgpe_pkg::ByteW-1:0]    job_bits_r;
  logic [bgpe_pkg::ByteW-1:0]    job_mask_r, job_mask_nxt;

  // Output register
  logic                          out_valid_r;
  logic [bgpe_pkg::CoordW-1:0]   out_x_r, out_y_r;
  logic [bgpe_pkg::ColorW-1:0]   out_color_r;
  logic                          out_last_r;

  logic                          in_xfer;
  logic [bgpe_pkg::ColW-1:0]     half, rem, col_eff;
  logic [bgpe_pkg::CoordW-1:0]   base_eff, y_eff;
  logic [bgpe_pkg::ByteCntW-1:0] bcnt_eff, bcnt_inc;
  logic [bgpe_pkg::SizeW-1:0]    size_eff;
  logic                          transp_eff, active_eff, row_end;
  logic [bgpe_pkg::ByteW-1:0]    new_mask;

  logic [bgpe_pkg::ByteW-1:0]    low_bit, rest_mask;
  logic [bgpe_pkg::BitIdxW-1:0]  low_idx;
  logic                          adv, job_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r <= bgpe_pkg::FG_RESET;
      bg_color_r <= bgpe_pkg::BG_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == bgpe_pkg::CFG_FG_COLOR) fg_color_r <= cfg_data[bgpe_pkg::ColorW-1:0];
      if (cfg_idx == bgpe_pkg::CFG_BG_COLOR) bg_color_r <= cfg_data[bgpe_pkg::ColorW-1:0];
    end
  end

  // Pick the glyph context this byte runs in
  always_comb begin
    if (in_ch.glyph_start) begin
      base_eff   = in_ch.origin_x;
      y_eff      = in_ch.origin_y;
      size_eff   = in_ch.size_code;
      transp_eff = in_ch.transparent;
      col_eff    = '0;
      bcnt_eff   = '0;
      active_eff = 1'b1;
    end else begin
      base_eff   = base_x_r;
      y_eff      = cur_y_r;
      size_eff   = size_r;
      transp_eff = transp_r;
      col_eff    = col_r;
      bcnt_eff   = bcnt_r;
      active_eff = active_r;
    end
  end

  // Decode the byte: which bits write, where the row ends
  always_comb begin
    half    = bgpe_pkg::half_of(size_eff);
    rem     = half - col_eff;
    row_end = (rem <= 5'd8);
    for (int j = 0; j < bgpe_pkg::ByteW; j++) begin
      new_mask[j] = active_eff && (5'(j) < rem) && (in_ch.font_byte[j] || !transp_eff);
    end
    bcnt_inc = bcnt_eff + 7'd1;
  end

  // Advance the glyph state on a transfer
  always_comb begin
    base_x_nxt = base_x_r;
    cur_y_nxt  = cur_y_r;
    col_nxt    = col_r;
    bcnt_nxt   = bcnt_r;
    size_nxt   = size_r;
    transp_nxt = transp_r;
    active_nxt = active_r;
    if (in_xfer && active_eff) begin
      base_x_nxt = base_eff;
      size_nxt   = size_eff;
      transp_nxt = transp_eff;
      cur_y_nxt  = row_end ? y_eff + 16'd1 : y_eff;
      col_nxt    = row_end ? '0 : col_eff + 5'd8;
      bcnt_nxt   = bcnt_inc;
      active_nxt = (bcnt_inc < bgpe_pkg::bytes_of(size_eff));
    end
  end

  // Lowest pending pixel of the job
  always_comb begin
    low_bit   = job_mask_r & (~job_mask_r + 8'd1);
    rest_mask = job_mask_r & ~low_bit;
    low_idx   = '0;
    for (int j = 0; j < bgpe_pkg::ByteW; j++) begin
      if (low_bit[j]) low_idx = 3'(j);
    end
  end

  assign adv          = (job_mask_r != '0) && (!out_valid_r || out_ch.ready);
  assign job_free     = (job_mask_r == '0) || (adv && (rest_mask == '0));
  assign in_ch.ready  = job_free;
  assign in_xfer      = in_ch.valid && job_free;

  always_comb begin
    job_mask_nxt = job_mask_r;
    if (in_xfer)  job_mask_nxt = new_mask;
    else if (adv) job_mask_nxt = rest_mask;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r    <= '0;
      cur_y_r     <= '0;
      col_r       <= '0;
      bcnt_r      <= '0;
      size_r      <= '0;
      transp_r    <= 1'b0;
      active_r    <= 1'b0;
      job_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_x_r    <= base_x_nxt;
      cur_y_r     <= cur_y_nxt;
      col_r       <= col_nxt;
      bcnt_r      <= bcnt_nxt;
      size_r      <= size_nxt;
      transp_r    <= transp_nxt;
      active_r    <= active_nxt;
      job_mask_r  <= job_mask_nxt;
      if (adv)               out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Load the job payload on a transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      job_x_r    <= base_eff + {11'd0, col_eff};
      job_y_r    <= y_eff;
      job_bits_r <= in_ch.font_byte;
    end
  end

  // Issue one pixel into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r     <= job_x_r + {13'd0, low_idx};
      out_y_r     <= job_y_r;
      out_color_r <= job_bits_r[low_idx] ? fg_color_r : bg_color_r;
      out_last_r  <= (rest_mask == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.last        = out_last_r;

endmodule

// File: hdl/bgpe_checker.sv
`timescale 1ns / 1ps

module bgpe_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_glyph_start,
  input logic                          in_transparent,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bgpe_pkg::CoordW-1:0]   out_pixel_x,
  input logic [bgpe_pkg::CoordW-1:0]   out_pixel_y,
  input logic [bgpe_pkg::ColorW-1:0]   out_pixel_color,
  input logic                          out_last
);

  // No pixel right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pixel valid right after reset");

  // Stalled pixel stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel dropped while stalled");

  // Stalled pixel keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_pixel_color) && $stable(out_last))
    else $error("pixel payload changed while stalled");

  // An opaque glyph's first byte writes at least six pixels, so no byte follows at once
  a_opaque_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_glyph_start && !in_transparent |=> !in_ready)
    else $error("input taken while a multi-pixel byte is pending");

endmodule

bind bitmap_glyph_pixel_expander_unit bgpe_checker u_bgpe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_glyph_start  (in_ch.glyph_start),
  .in_transparent  (in_ch.transparent),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pixel_x     (out_ch.pixel_x),
  .out_pixel_y     (out_ch.pixel_y),
  .out_pixel_color (out_ch.pixel_color),
  .out_last        (out_ch.last)
);
